/* sv/page_id_free_list_allocator_top_defines.svh */
// Assertion macros shared by the page allocator's checker.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef PAGE_ID_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_ID_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PGFL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PGFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pgfl_pkg.sv */
// Types and constants of the page number allocator.
// Depends on nothing; used by the top level and the checker.
package pgfl_pkg;

	localparam int PAGE_W = 10;
	localparam int CFG_W  = 11;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STATUS_OK     = 3'd0,
		STATUS_RANGE  = 3'd1,
		STATUS_DOUBLE = 3'd2,
		STATUS_FULL   = 3'd3,
		STATUS_BROKEN = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] granted_page;
		logic              grew;
		status_t           status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_POP
	} state_t;

endpackage

/* sv/pgfl_ram.sv */
// Single-port synchronous RAM with registered read data.
// Depends on nothing; holds the free stack and the free bitmap.
module pgfl_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* sv/page_id_free_list_allocator_top.sv */
// Page number allocator: free stack plus free bitmap, both in single-port RAMs.
// A free, or an allocate while the stack is empty, ends in S_LOOK; an allocate that
// pops the stack goes on to S_POP, as the bitmap is read at the number from the stack.
// After reset a clearing pass zeroes every bitmap entry with busy high.
// Results are strobed by done for one cycle and cannot be held off.
module page_id_free_list_allocator_top #(
	parameter int MAX_PAGES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pgfl_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             start,
	input  pgfl_pkg::req_t                   req,
	output logic                             busy,
	output logic                             done,
	output pgfl_pkg::rsp_t                   result
);

	import pgfl_pkg::*;

	localparam int AW   = $clog2(MAX_PAGES);
	localparam int CW   = $clog2(MAX_PAGES + 1);
	localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [CMPW-1:0] MAXC     = CMPW'(MAX_PAGES);
	localparam logic [AW-1:0]   CLR_LAST = AW'(MAX_PAGES - 1);

	state_t state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     high_water_q;
	logic [AW-1:0]     clr_q;
	cmd_t              cmd_q;
	logic [PAGE_W-1:0] pn_q;
	logic [PAGE_W-1:0] id_q;
	logic              done_q;
	rsp_t              result_q;

	logic              stk_en, stk_we;
	logic [AW-1:0]     stk_addr;
	logic [PAGE_W-1:0] stk_wdata, stk_rdata;
	logic              bm_en, bm_we;
	logic [AW-1:0]     bm_addr;
	logic              bm_wdata, bm_rdata;

	logic              done_d;
	rsp_t              rsp_d;
	logic              cnt_inc, cnt_dec, hw_inc, id_load;

	logic [CMPW-1:0]   pn_c, hw_c, cnt_c, id_c, newid_c, cfg_c;
	logic [CW-1:0]     cnt_m1;

	assign pn_c    = CMPW'(pn_q);
	assign hw_c    = CMPW'(high_water_q);
	assign cnt_c   = CMPW'(count_q);
	assign id_c    = CMPW'(id_q);
	assign newid_c = CMPW'(stk_rdata);
	assign cfg_c   = CMPW'(cfg_wdata);
	assign cnt_m1  = count_q - 1'b1;

	pgfl_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_stack (
		.clk   (clk),
		.en    (stk_en),
		.we    (stk_we),
		.addr  (stk_addr),
		.wdata (stk_wdata),
		.rdata (stk_rdata)
	);

	pgfl_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_bitmap (
		.clk   (clk),
		.en    (bm_en),
		.we    (bm_we),
		.addr  (bm_addr),
		.wdata (bm_wdata),
		.rdata (bm_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_LOOK;
			end
			S_LOOK: begin
				if (cmd_q == CMD_ALLOC && count_q != '0) begin
					state_d = S_POP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_POP: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		stk_en    = 1'b0;
		stk_we    = 1'b0;
		stk_addr  = cnt_m1[AW-1:0];
		stk_wdata = pn_q;
		bm_en     = 1'b0;
		bm_we     = 1'b0;
		bm_addr   = pn_c[AW-1:0];
		bm_wdata  = 1'b0;
		done_d    = 1'b0;
		rsp_d     = '{granted_page: '0, grew: 1'b0, status: STATUS_OK};
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		hw_inc    = 1'b0;
		id_load   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				bm_en   = 1'b1;
				bm_we   = 1'b1;
				bm_addr = clr_q;
			end
			S_IDLE: begin
				// Read the stack top and the bitmap entry of the page in the word.
				if (start) begin
					stk_en  = 1'b1;
					bm_en   = 1'b1;
					bm_addr = AW'(CMPW'(req.page_number));
				end
			end
			S_LOOK: begin
				if (cmd_q == CMD_FREE) begin
					done_d = 1'b1;
					if (pn_c >= hw_c || pn_c >= MAXC) begin
						rsp_d.status = STATUS_RANGE;
					end else if (bm_rdata) begin
						rsp_d.status = STATUS_DOUBLE;
					end else if (cnt_c >= MAXC) begin
						rsp_d.status = STATUS_FULL;
					end else begin
						stk_en   = 1'b1;
						stk_we   = 1'b1;
						stk_addr = count_q[AW-1:0];
						bm_en    = 1'b1;
						bm_we    = 1'b1;
						bm_wdata = 1'b1;
						cnt_inc  = 1'b1;
					end
				end else if (count_q != '0) begin
					// The popped number must still be marked free.
					id_load = 1'b1;
					bm_en   = 1'b1;
					bm_addr = newid_c[AW-1:0];
				end else begin
					done_d = 1'b1;
					if (hw_c >= MAXC) begin
						rsp_d.status = STATUS_FULL;
					end else begin
						rsp_d.granted_page = PAGE_W'(hw_c);
						rsp_d.grew         = 1'b1;
						hw_inc             = 1'b1;
					end
				end
			end
			S_POP: begin
				done_d = 1'b1;
				if (id_c < MAXC && bm_rdata) begin
					rsp_d.granted_page = id_q;
					bm_en              = 1'b1;
					bm_we              = 1'b1;
					bm_addr            = id_c[AW-1:0];
					cnt_dec            = 1'b1;
				end else begin
					rsp_d.status = STATUS_BROKEN;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			count_q      <= '0;
			high_water_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cfg_we) begin
				high_water_q <= (cfg_c > MAXC) ? CW'(MAXC) : CW'(cfg_c);
			end else if (hw_inc) begin
				high_water_q <= high_water_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= req.cmd;
			pn_q  <= req.page_number;
		end
		if (id_load) id_q <= stk_rdata;
		if (done_d) result_q <= rsp_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* sv/pgfl_checker.sv */
// Port-level checks of the page allocator, bound to the top level.
// Depends on pgfl_pkg and the assertion macros in the defines header.
`include "page_id_free_list_allocator_top_defines.svh"

module pgfl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input pgfl_pkg::rsp_t result
);

	import pgfl_pkg::*;

	`PGFL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`PGFL_ASSERT_NEXT(a_single_done, done, !done, "two results strobed back to back")
	`PGFL_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without an item in flight")
	`PGFL_ASSERT_NOW(a_fail_clean, done && result.status != STATUS_OK, result.granted_page == '0 && !result.grew, "failed result carries a page or growth")
	`PGFL_ASSERT_NOW(a_grew_ok, done && result.grew, result.status == STATUS_OK, "growth reported on a failed result")

endmodule

bind page_id_free_list_allocator_top pgfl_checker u_pgfl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
